FILE: design/pidfd_pkg.sv
// shared types, constants and fixed-point helpers for the pid controller
package pidfd_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_SUM,
        ST_DONE
    } state_t;

    // arithmetic step that the shared serial unit is working on
    typedef enum logic [2:0] {
        OP_P,
        OP_SLOPE,
        OP_FILT,
        OP_D,
        OP_PD,
        OP_I1,
        OP_I2,
        OP_INC
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [2:0] CFG_INTEGRAL_GAIN  = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [2:0] CFG_FILTER_TIME_MS = 3'd3;
    localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd5;
    localparam logic [2:0] CFG_YAW_MODE       = 3'd6;
    localparam logic [2:0] CFG_DRIVE_ENABLE   = 3'd7;

    // integration band limits in Q16.16
    localparam logic [31:0] YAW_BAND_HIGH = 32'd983040;
    localparam logic [31:0] YAW_BAND_LOW  = 32'd19660;
    localparam logic [31:0] STD_BAND_HIGH = 32'd655360;
    localparam logic [31:0] STD_BAND_LOW  = 32'd6553;

    // longest time gap in ms before the controller restarts
    localparam logic [31:0] GAP_MS = 32'd1000;
    // ms per second, used for the slope and the integrator step
    localparam logic [31:0] MS_PER_S = 32'd1000;

    // serial unit cycle counts
    localparam logic [5:0] MUL_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST = 6'd63;

    // magnitude of a signed 32 bit value
    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // saturate a 35 bit signed value to 32 bits
    function automatic logic signed [31:0] sat35(input logic signed [34:0] x);
        if (x > 35'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -35'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // signed product from magnitude and sign, floor shift by 16, saturate
    function automatic logic signed [31:0] mulq_fin(input logic [63:0] mag,
                                                    input logic neg);
        logic signed [64:0] v;
        logic signed [48:0] s;
        v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        s = v[64:16];
        if (s > 49'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (s < -49'sd2147483648)
            return 32'sh80000000;
        else
            return s[31:0];
    endfunction

    // signed quotient from magnitude and sign, saturated to 32 bits
    function automatic logic signed [31:0] satq32(input logic [63:0] q,
                                                  input logic neg);
        if (!neg)
            return (q > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : q[31:0];
        else
            return (q > 64'h8000_0000) ? 32'sh80000000 : (~q[31:0] + 32'd1);
    endfunction

    // signed quotient from magnitude and sign, for quotients below 2^33
    function automatic logic signed [34:0] sq35(input logic [63:0] q,
                                                input logic neg);
        return neg ? -$signed({2'b00, q[32:0]}) : $signed({2'b00, q[32:0]});
    endfunction

    // clamp a 35 bit signed value to +-lim
    function automatic logic signed [31:0] clamp35(input logic signed [34:0] x,
                                                   input logic [30:0] lim);
        logic signed [34:0] l;
        logic signed [34:0] nl;
        l  = $signed({4'b0000, lim});
        nl = -l;
        if (x > l)
            return l[31:0];
        else if (x < nl)
            return nl[31:0];
        else
            return x[31:0];
    endfunction

endpackage

FILE: design/pid_controller_filtered_derivative_top.sv
// pid controller with filtered derivative and integral band, bit-serial datapath
// a result beat follows the p step, the optional derivative steps, the pd step and,
//   when integration is active, the integrator steps
// one item at a time: in_stall stays high from an accepted beat until its result beat
//   is issued; the shared bit-serial unit runs every multiply and divide step
// reset: asynchronous active low, clears configuration, controller state and handshakes
module pid_controller_filtered_derivative_top
    import pidfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] err_sample,
    input  logic signed [31:0] term_scale,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] drive,
    output logic signed [31:0] integ_value
);

    // configuration
    logic signed [31:0] prop_gain_reg;
    logic signed [31:0] integral_gain_reg;
    logic signed [31:0] deriv_gain_reg;
    logic [30:0]        filter_time_ms_reg;
    logic [30:0]        integral_limit_reg;
    logic [30:0]        output_limit_reg;
    logic               yaw_mode_reg;
    logic               drive_enable_reg;

    // control
    state_t     state_reg, state_next;
    op_t        op_reg, op_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // controller state
    logic [31:0]        prev_time_reg, prev_time_next;
    logic signed [31:0] integ_acc_reg, integ_acc_next;
    logic signed [31:0] prev_err_reg, prev_err_next;
    logic signed [31:0] filt_deriv_reg, filt_deriv_next;
    logic               deriv_valid_reg, deriv_valid_next;

    // per-item working values
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] scale_reg, scale_next;
    logic [9:0]         dt_reg, dt_next;
    logic               do_d_reg, do_d_next;
    logic               do_i_reg, do_i_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] d_reg, d_next;
    logic signed [31:0] pd_reg, pd_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] t_reg, t_next;
    logic signed [31:0] slope_reg, slope_next;

    // shared serial multiply / divide unit
    logic [31:0] mul_a_reg, mul_a_next;
    logic        neg_reg, neg_next;
    logic [31:0] den_reg, den_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] rem_reg, rem_next;

    // result beat
    logic signed [31:0] drive_reg, drive_next;
    logic signed [31:0] integ_value_reg, integ_value_next;

    // input beat decode
    logic        in_fire;
    logic [31:0] dt_raw;
    logic        restart;
    logic        dt_nz;
    logic [31:0] err_mag;
    logic        in_band;
    logic        out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign drive       = drive_reg;
    assign integ_value = integ_value_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // time step, restart detection and integration band
    always_comb
    begin
        dt_raw  = now_ms - prev_time_reg;
        restart = (prev_time_reg == 32'd0) || (dt_raw > GAP_MS);
        dt_nz   = !restart && (dt_raw != 32'd0);
        err_mag = abs32(err_sample);
        if (yaw_mode_reg)
            in_band = (err_mag < YAW_BAND_HIGH) && (err_mag > YAW_BAND_LOW);
        else
            in_band = (err_mag < STD_BAND_HIGH) && (err_mag > STD_BAND_LOW);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_SET;
            end
            ST_SET:
                state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    if (op_reg inside {OP_SLOPE, OP_FILT, OP_INC})
                        state_next = ST_DIV;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                unique case (op_reg)
                    OP_P:     state_next = do_d_reg ? ST_SET : ST_SUM;
                    OP_D:     state_next = ST_SUM;
                    OP_PD:    state_next = do_i_reg ? ST_SET : ST_DONE;
                    OP_INC:   state_next = ST_DONE;
                    default:  state_next = ST_SET;
                endcase
            end
            ST_SUM:
                state_next = ST_SET;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [31:0]        opa;
        logic [31:0]        opb;
        logic signed [32:0] diff;
        logic [32:0]        sum33;
        logic [32:0]        trial_in;
        logic [33:0]        trial;
        logic signed [34:0] wide;

        op_next          = op_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        prev_time_next   = prev_time_reg;
        integ_acc_next   = integ_acc_reg;
        prev_err_next    = prev_err_reg;
        filt_deriv_next  = filt_deriv_reg;
        deriv_valid_next = deriv_valid_reg;
        err_next         = err_reg;
        scale_next       = scale_reg;
        dt_next          = dt_reg;
        do_d_next        = do_d_reg;
        do_i_next        = do_i_reg;
        p_next           = p_reg;
        d_next           = d_reg;
        pd_next          = pd_reg;
        acc_next         = acc_reg;
        t_next           = t_reg;
        slope_next       = slope_reg;
        mul_a_next       = mul_a_reg;
        neg_next         = neg_reg;
        den_next         = den_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        drive_next       = drive_reg;
        integ_value_next = integ_value_reg;
        opa   = 32'd0;
        opb   = 32'd0;
        diff  = 33'sd0;
        sum33 = 33'd0;
        trial_in = 33'd0;
        trial = 34'd0;
        wide  = 35'sd0;

        // result beat taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            // take an input beat, apply restart rules
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    err_next       = err_sample;
                    scale_next     = term_scale;
                    prev_time_next = now_ms;
                    dt_next        = restart ? 10'd0 : dt_raw[9:0];
                    do_d_next      = (deriv_gain_reg != 32'sd0) && dt_nz;
                    do_i_next      = in_band && (integral_gain_reg != 32'sd0) && dt_nz;
                    d_next         = 32'sd0;
                    op_next        = OP_P;
                    if (restart)
                    begin
                        integ_acc_next   = 32'sd0;
                        deriv_valid_next = 1'b0;
                    end
                end
            end
            // load operand magnitudes and divisor for the current step
            ST_SET:
            begin
                unique case (op_reg)
                    OP_P:
                    begin
                        opa      = abs32(err_reg);
                        opb      = abs32(prop_gain_reg);
                        neg_next = err_reg[31] ^ prop_gain_reg[31];
                    end
                    OP_SLOPE:
                    begin
                        diff     = $signed({err_reg[31], err_reg})
                                 - $signed({prev_err_reg[31], prev_err_reg});
                        opa      = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
                        opb      = MS_PER_S;
                        neg_next = diff[32];
                        den_next = {22'd0, dt_reg};
                    end
                    OP_FILT:
                    begin
                        diff     = $signed({slope_reg[31], slope_reg})
                                 - $signed({filt_deriv_reg[31], filt_deriv_reg});
                        opa      = diff[32] ? (~diff[31:0] + 32'd1) : diff[31:0];
                        opb      = {6'd0, dt_reg, 16'd0};
                        neg_next = diff[32];
                        den_next = {1'b0, filter_time_ms_reg} + {6'd0, dt_reg, 16'd0};
                    end
                    OP_D:
                    begin
                        opa      = abs32(deriv_gain_reg);
                        opb      = abs32(filt_deriv_reg);
                        neg_next = deriv_gain_reg[31] ^ filt_deriv_reg[31];
                    end
                    OP_PD:
                    begin
                        opa      = abs32(pd_reg);
                        opb      = abs32(scale_reg);
                        neg_next = pd_reg[31] ^ scale_reg[31];
                    end
                    OP_I1:
                    begin
                        opa      = abs32(err_reg);
                        opb      = abs32(integral_gain_reg);
                        neg_next = err_reg[31] ^ integral_gain_reg[31];
                    end
                    OP_I2:
                    begin
                        opa      = abs32(t_reg);
                        opb      = abs32(scale_reg);
                        neg_next = t_reg[31] ^ scale_reg[31];
                    end
                    OP_INC:
                    begin
                        opa      = abs32(t_reg);
                        opb      = {22'd0, dt_reg};
                        neg_next = t_reg[31];
                        den_next = MS_PER_S;
                    end
                    default:
                    begin
                        opa = 32'd0;
                        opb = 32'd0;
                    end
                endcase
                mul_a_next = opa;
                prod_next  = {32'd0, opb};
                rem_next   = 32'd0;
                cnt_next   = 6'd0;
            end
            // shift-add multiply, one multiplier bit per cycle
            ST_MUL:
            begin
                sum33 = prod_reg[0] ? ({1'b0, prod_reg[63:32]} + {1'b0, mul_a_reg})
                                    : {1'b0, prod_reg[63:32]};
                prod_next = {sum33, prod_reg[31:1]};
                cnt_next  = (cnt_reg == MUL_LAST) ? 6'd0 : cnt_reg + 6'd1;
            end
            // restoring divide, one quotient bit per cycle
            ST_DIV:
            begin
                trial_in = {rem_reg, prod_reg[63]};
                trial    = {1'b0, trial_in} - {2'b00, den_reg};
                if (!trial[33])
                    rem_next = trial[31:0];
                else
                    rem_next = trial_in[31:0];
                prod_next = {prod_reg[62:0], !trial[33]};
                cnt_next  = cnt_reg + 6'd1;
            end
            // retire the step result
            ST_FIN:
            begin
                unique case (op_reg)
                    OP_P:
                    begin
                        p_next = mulq_fin(prod_reg, neg_reg);
                        if (do_d_reg)
                        begin
                            if (deriv_valid_reg)
                                op_next = OP_SLOPE;
                            else
                            begin
                                // unprimed filter starts from zero slope
                                slope_next       = 32'sd0;
                                filt_deriv_next  = 32'sd0;
                                deriv_valid_next = 1'b1;
                                op_next          = OP_FILT;
                            end
                        end
                        else
                            op_next = OP_PD;
                    end
                    OP_SLOPE:
                    begin
                        slope_next = satq32(prod_reg, neg_reg);
                        op_next    = OP_FILT;
                    end
                    OP_FILT:
                    begin
                        wide = $signed({{3{filt_deriv_reg[31]}}, filt_deriv_reg})
                             + sq35(prod_reg, neg_reg);
                        filt_deriv_next = sat35(wide);
                        prev_err_next   = err_reg;
                        op_next         = OP_D;
                    end
                    OP_D:
                    begin
                        d_next  = mulq_fin(prod_reg, neg_reg);
                        op_next = OP_PD;
                    end
                    OP_PD:
                    begin
                        acc_next = mulq_fin(prod_reg, neg_reg);
                        op_next  = OP_I1;
                    end
                    OP_I1:
                    begin
                        t_next  = mulq_fin(prod_reg, neg_reg);
                        op_next = OP_I2;
                    end
                    OP_I2:
                    begin
                        t_next  = mulq_fin(prod_reg, neg_reg);
                        op_next = OP_INC;
                    end
                    OP_INC:
                    begin
                        wide = $signed({{3{integ_acc_reg[31]}}, integ_acc_reg})
                             + sq35(prod_reg, neg_reg);
                        integ_acc_next = clamp35(wide, integral_limit_reg);
                    end
                    default:
                        op_next = OP_P;
                endcase
            end
            // p + d, saturated
            ST_SUM:
            begin
                wide    = $signed({{3{p_reg[31]}}, p_reg}) + $signed({{3{d_reg[31]}}, d_reg});
                pd_next = sat35(wide);
            end
            // final clamp and result beat
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (do_i_reg)
                        wide = $signed({{3{acc_reg[31]}}, acc_reg})
                             + $signed({{3{integ_acc_reg[31]}}, integ_acc_reg});
                    else
                        wide = $signed({{3{acc_reg[31]}}, acc_reg});
                    drive_next       = drive_enable_reg ? clamp35(wide, output_limit_reg)
                                                        : 32'sd0;
                    integ_value_next = integ_acc_reg;
                    out_valid_next   = 1'b1;
                end
            end
            default:
            begin
                cnt_next = 6'd0;
            end
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            op_reg             <= OP_P;
            cnt_reg            <= 6'd0;
            out_valid_reg      <= 1'b0;
            prop_gain_reg      <= 32'sd0;
            integral_gain_reg  <= 32'sd0;
            deriv_gain_reg     <= 32'sd0;
            filter_time_ms_reg <= 31'd0;
            integral_limit_reg <= 31'd0;
            output_limit_reg   <= 31'd0;
            yaw_mode_reg       <= 1'b0;
            drive_enable_reg   <= 1'b0;
            prev_time_reg      <= 32'd0;
            integ_acc_reg      <= 32'sd0;
            prev_err_reg       <= 32'sd0;
            filt_deriv_reg     <= 32'sd0;
            deriv_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            prev_time_reg   <= prev_time_next;
            integ_acc_reg   <= integ_acc_next;
            prev_err_reg    <= prev_err_next;
            filt_deriv_reg  <= filt_deriv_next;
            deriv_valid_reg <= deriv_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data;
                    CFG_INTEGRAL_GAIN:  integral_gain_reg  <= cfg_data;
                    CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data;
                    CFG_FILTER_TIME_MS: filter_time_ms_reg <= cfg_data[30:0];
                    CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[30:0];
                    CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[30:0];
                    CFG_YAW_MODE:       yaw_mode_reg       <= cfg_data[0];
                    CFG_DRIVE_ENABLE:   drive_enable_reg   <= cfg_data[0];
                    default:            yaw_mode_reg       <= yaw_mode_reg;
                endcase
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        err_reg         <= err_next;
        scale_reg       <= scale_next;
        dt_reg          <= dt_next;
        do_d_reg        <= do_d_next;
        do_i_reg        <= do_i_next;
        p_reg           <= p_next;
        d_reg           <= d_next;
        pd_reg          <= pd_next;
        acc_reg         <= acc_next;
        t_reg           <= t_next;
        slope_reg       <= slope_next;
        mul_a_reg       <= mul_a_next;
        neg_reg         <= neg_next;
        den_reg         <= den_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        drive_reg       <= drive_next;
        integ_value_reg <= integ_value_next;
    end

    // multiply step counter stays below 32
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> !cnt_reg[5])
        else $error("multiply step count overran");

    // a result beat only appears from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside final step");

    // derivative and integrator steps never run with a zero time step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SET && (op_reg == OP_FILT || op_reg == OP_INC)) |-> dt_reg != 10'd0)
        else $error("divide step entered with zero dt");

    // integrator stays inside its clamp after an update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && op_reg == OP_INC) |=>
            (integ_acc_reg <= $signed({1'b0, integral_limit_reg})
             && integ_acc_reg >= -$signed({1'b0, integral_limit_reg})))
        else $error("integrator outside its clamp");

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the pid controller with filtered derivative
`timescale 1ns / 1ps

// queue of predicted controller outputs, checked in order as result beats arrive
class pid_scoreboard;
    logic signed [31:0] exp_drive[$];
    logic signed [31:0] exp_integ[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // note one predicted result for an accepted input beat
    function void note_input(logic signed [31:0] d, logic signed [31:0] i);
        exp_drive.push_back(d);
        exp_integ.push_back(i);
    endfunction

    // compare one result beat with the oldest prediction
    function void check_result(logic signed [31:0] d, logic signed [31:0] i);
        logic signed [31:0] ed;
        logic signed [31:0] ei;
        if (exp_drive.size() == 0) begin
            $display("%0t: result beat with nothing expected, drive %0d integ %0d",
                     $time, d, i);
            errors++;
            return;
        end
        ed = exp_drive.pop_front();
        ei = exp_integ.pop_front();
        if (d !== ed) begin
            $display("%0t: drive mismatch, expected %0d actual %0d", $time, ed, d);
            errors++;
        end
        if (i !== ei) begin
            $display("%0t: integ_value mismatch, expected %0d actual %0d", $time, ei, i);
            errors++;
        end
    endfunction

    function int pending();
        return exp_drive.size();
    endfunction
endclass

module testbench;
    import pidfd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] err_sample;
    logic signed [31:0] term_scale;
    logic [31:0]        now_ms;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] drive;
    logic signed [31:0] integ_value;

    pid_controller_filtered_derivative_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .err_sample (err_sample),
        .term_scale (term_scale),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .integ_value(integ_value)
    );

    pid_scoreboard sb;

    // predictor copy of configuration
    logic signed [31:0] kp, ki, kd;
    logic [30:0]        rc_ms, i_lim, o_lim;
    logic               yaw, enable;

    // predictor copy of controller state
    logic [31:0]        last_ms;
    logic signed [31:0] integ, last_err, filt;
    logic               primed;

    // receiver control
    logic               hold_off;
    int                 hold_cycles;
    bit                 stim_done;

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // saturate to 32 bit signed
    function automatic logic signed [31:0] sat(input longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    // q16.16 product, floor shift, saturate
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        longint pr;
        pr = longint'(a) * longint'(b);
        return sat(pr >>> 16);
    endfunction

    function automatic longint clamp_mag(input longint x, input logic [30:0] lim);
        longint l;
        l = longint'(lim);
        if (x > l)
            return l;
        if (x < -l)
            return -l;
        return x;
    endfunction

    // one controller step of the predictor
    task automatic predict_step(input logic signed [31:0] e, input logic signed [31:0] sc,
                                input logic [31:0] t);
        logic [31:0]        dt;
        logic signed [31:0] p, d, pd, ti;
        longint             acc, mag, slope, den, q, inc;
        logic               band;
        dt = t - last_ms;
        d = 0;
        if (last_ms == 0 || dt > GAP_MS) begin
            dt = 0;
            integ = 0;
            primed = 1'b0;
        end
        last_ms = t;
        p = qmul(e, kp);
        // filtered derivative
        if (kd != 0 && dt > 0) begin
            if (!primed) begin
                slope = 0;
                filt = 0;
                primed = 1'b1;
            end else begin
                slope = sat(((longint'(e) - longint'(last_err)) * 1000) / longint'(dt));
            end
            den = longint'(rc_ms) + (longint'(dt) << 16);
            q = ((slope - longint'(filt)) * (longint'(dt) << 16)) / den;
            filt = sat(longint'(filt) + q);
            last_err = e;
            d = qmul(kd, filt);
        end
        pd = sat(longint'(p) + longint'(d));
        acc = longint'(qmul(pd, sc));
        // integral separation band
        mag = e < 0 ? -longint'(e) : longint'(e);
        if (yaw)
            band = mag < longint'(YAW_BAND_HIGH) && mag > longint'(YAW_BAND_LOW);
        else
            band = mag < longint'(STD_BAND_HIGH) && mag > longint'(STD_BAND_LOW);
        if (band && ki != 0 && dt > 0) begin
            ti = qmul(qmul(e, ki), sc);
            inc = (longint'(ti) * longint'(dt)) / 1000;
            integ = 32'(clamp_mag(longint'(integ) + inc, i_lim));
            acc += longint'(integ);
        end
        acc = clamp_mag(acc, o_lim);
        if (!enable)
            acc = 0;
        sb.note_input(acc[31:0], integ);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            CFG_PROP_GAIN:      kp = val;
            CFG_INTEGRAL_GAIN:  ki = val;
            CFG_DERIV_GAIN:     kd = val;
            CFG_FILTER_TIME_MS: rc_ms = val[30:0];
            CFG_INTEGRAL_LIMIT: i_lim = val[30:0];
            CFG_OUTPUT_LIMIT:   o_lim = val[30:0];
            CFG_YAW_MODE:       yaw = val[0];
            CFG_DRIVE_ENABLE:   enable = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // short idle mostly, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // offer one input beat and wait for acceptance
    task automatic send_beat(input logic signed [31:0] e, input logic signed [31:0] sc,
                             input logic [31:0] t, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g) @(negedge clk);
        in_valid   = 1'b1;
        err_sample = e;
        term_scale = sc;
        now_ms     = t;
        // stall is stable between edges, so the next rising edge accepts
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        predict_step(e, sc, t);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // wait until every result has arrived, then let the block settle
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    // error value near the band edges, in a general range, sometimes any 32 bits
    function automatic logic signed [31:0] rand_err();
        int r;
        logic signed [31:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0, 1: v = $urandom;
            2:    v = $urandom_range(19650, 19670);
            3:    v = $urandom_range(6540, 6560);
            4:    v = $urandom_range(655350, 655370);
            5:    v = $urandom_range(983030, 983050);
            default: v = $urandom_range(0, 1100000);
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic signed [31:0] rand_scale();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $signed($urandom_range(0, 196608)) - 32'sd65536;
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 5) == 0)
            return $urandom;
        return $signed($urandom_range(0, 1310720)) - 32'sd655360;
    endfunction

    // random time step: mostly in range, sometimes restart causes
    function automatic logic [31:0] next_time(input logic [31:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 0;
        if (r < 7)
            return t + $urandom_range(1001, 100000);
        if (r < 10)
            return t;
        if (r < 12)
            return t + 1000;
        if (r < 14)
            return $urandom;
        return t + $urandom_range(1, 50);
    endfunction

    // random configuration set
    task automatic random_config(input int kind);
        write_reg(CFG_PROP_GAIN, rand_gain());
        write_reg(CFG_INTEGRAL_GAIN, ($urandom_range(0, 5) == 0) ? 32'd0 : rand_gain());
        write_reg(CFG_DERIV_GAIN, ($urandom_range(0, 5) == 0) ? 32'd0 : rand_gain());
        write_reg(CFG_FILTER_TIME_MS, kind == 0 ? 32'd0 : kind == 1 ? 32'h7FFFFFFF :
                  {1'b0, 31'($urandom_range(0, 32'h01000000))});
        write_reg(CFG_INTEGRAL_LIMIT, kind == 1 ? 32'h7FFFFFFF : kind == 0 ? 32'd0 :
                  {1'b0, 31'($urandom_range(0, 32'h00200000))});
        write_reg(CFG_OUTPUT_LIMIT, kind == 1 ? 32'h7FFFFFFF : kind == 0 ? 32'd0 :
                  ($urandom_range(0, 3) == 0 ? {1'b0, 31'($urandom)} :
                   {1'b0, 31'($urandom_range(0, 32'h00400000))}));
        write_reg(CFG_YAW_MODE, $urandom_range(0, 1));
        write_reg(CFG_DRIVE_ENABLE, kind == 0 ? 32'd0 :
                  {31'd0, ($urandom_range(0, 7) != 0)});
    endtask

    // result side: random stalls, one long hold-off
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_off = 1'b0;
                out_stall = 1'b0;
            end else if (stim_done || $urandom_range(0, 9) < 7) begin
                out_stall = 1'b0;
            end else begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 99) < 95 ? $urandom_range(0, 3) :
                        $urandom_range(20, 300)) @(negedge clk);
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(drive, integ_value);
    end

    // run limit
    initial begin
        #60ms;
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial begin
        logic [31:0] t;
        sb = new();
        kp = 0; ki = 0; kd = 0; rc_ms = 0; i_lim = 0; o_lim = 0; yaw = 0; enable = 0;
        last_ms = 0; integ = 0; last_err = 0; filt = 0; primed = 1'b0;
        hold_off = 1'b0; hold_cycles = 0; stim_done = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; err_sample = '0; term_scale = '0; now_ms = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config gives zero drive
        send_beat(32'sd65536, 32'sd65536, 32'd5, 0);
        send_beat(32'sd65536, 32'sd65536, 32'd10, 0);
        drain();
        // directed: full gains, wide limits, band edges and extremes
        write_reg(CFG_PROP_GAIN, 32'sd65536);
        write_reg(CFG_INTEGRAL_GAIN, 32'sd131072);
        write_reg(CFG_DERIV_GAIN, 32'sd32768);
        write_reg(CFG_FILTER_TIME_MS, 32'd1000 << 16);
        write_reg(CFG_INTEGRAL_LIMIT, 32'h7FFFFFFF);
        write_reg(CFG_OUTPUT_LIMIT, 32'h7FFFFFFF);
        write_reg(CFG_YAW_MODE, 32'd0);
        write_reg(CFG_DRIVE_ENABLE, 32'd1);
        send_beat(32'sd6553, 32'sd65536, 32'd100, 0);
        send_beat(32'sd6554, 32'sd65536, 32'd110, 0);
        send_beat(32'sd655359, 32'sd65536, 32'd120, 0);
        send_beat(32'sd655360, 32'sd65536, 32'd120, 0);
        send_beat(-32'sd300000, 32'sd65536, 32'd1120, 0);
        send_beat(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'd1121, 0);
        send_beat(32'sh80000000, 32'sh80000000, 32'd1122, 0);
        send_beat(32'sh80000000, 32'sh7FFFFFFF, 32'd2123, 0);
        send_beat(32'sd100000, -32'sd65536, 32'd0, 0);
        send_beat(32'sd100000, 32'sd65536, 32'd3, 0);
        send_beat(32'sd100000, 32'sd65536, 32'hFFFFFFFF, 0);
        send_beat(32'sd100000, 32'sd65536, 32'd2, 0);
        drain();
        write_reg(CFG_YAW_MODE, 32'd1);
        write_reg(CFG_INTEGRAL_LIMIT, 32'd0);
        write_reg(CFG_OUTPUT_LIMIT, 32'd1);
        send_beat(32'sd19660, 32'sd65536, 32'd10, 0);
        send_beat(32'sd19661, 32'sd65536, 32'd20, 0);
        send_beat(32'sd983039, 32'sd65536, 32'd30, 0);
        send_beat(-32'sd983040, 32'sd65536, 32'd40, 0);
        drain();

        // random phases with changing configuration
        t = 32'd50;
        for (int ph = 0; ph < 24; ph++) begin
            random_config(ph == 3 ? 0 : ph == 7 ? 1 : 2);
            for (int k = 0; k < 80; k++) begin
                t = next_time(t);
                // receiver holds off while the sender keeps going
                if (ph == 5 && k == 2) begin
                    hold_cycles = 2000;
                    hold_off = 1'b1;
                end
                send_beat(rand_err(), rand_scale(), t, (ph % 4) != 1);
            end
            // sender pauses until all results are in
            drain();
        end
        stim_done = 1'b1;
        drain();
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

FILE: pid_controller_filtered_derivative_top.f
design/pidfd_pkg.sv
design/pid_controller_filtered_derivative_top.sv
bench/testbench.sv
